// ===== rtl/lpht_pkg.sv =====
package lpht_pkg;

  localparam int KEY_W    = 31;
  localparam int DATA_W   = 32;
  localparam int SLOT_W   = 4;
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 2;
  localparam int MARK_W   = 2;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

  // Slot marks.
  localparam logic [MARK_W-1:0] MARK_EMPTY   = 2'd0;
  localparam logic [MARK_W-1:0] MARK_USED    = 2'd1;
  localparam logic [MARK_W-1:0] MARK_DELETED = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  // The key is reduced modulo the table size in two steps: a reciprocal
  // multiply gives the quotient, then quotient times table size comes off the key.
  localparam int HASH_STEPS = 2;
  localparam int HASH_CNT_W = 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_HOME,
    S_CHECK
  } state_t;

  typedef struct packed {
    logic clr_en;
    logic load;
    logic hash_en;
    logic rd_home;
    logic rd_next;
    logic wr_used;
    logic wr_deleted;
    logic res_ok;
    logic res_nf;
    logic res_full;
  } lpht_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic              hash_done;
    logic              clear_done;
    logic [MARK_W-1:0] mark;
    logic              key_eq;
    logic              last;
  } lpht_stat_t;

endpackage

// ===== rtl/linear_probe_hash_table_top.sv =====
// Channel   Ports                              Transfer
// request   start, req_type, key, data_in      start high while busy is low
// result    done, status, data_out, slot_index done high for one cycle
//
// After reset, the block clears every slot mark, one slot a cycle, with busy high.
// A request reduces its key modulo TABLE_SIZE, addresses the home slot and then
// checks one slot per cycle from the slot memory, probing 1 to TABLE_SIZE slots
// before done rises. An unknown request code ends after the reduction. busy is
// low in the cycle that done is high, so the next request may be accepted there.
// The receiver cannot stall results.
module linear_probe_hash_table_top #(
  parameter int TABLE_SIZE = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [lpht_pkg::REQ_W-1:0]         req_type,
  input  logic [lpht_pkg::KEY_W-1:0]         key,
  input  logic signed [lpht_pkg::DATA_W-1:0] data_in,
  output logic                               done,
  output logic [lpht_pkg::STATUS_W-1:0]      status,
  output logic signed [lpht_pkg::DATA_W-1:0] data_out,
  output logic [lpht_pkg::SLOT_W-1:0]        slot_index
);

  lpht_pkg::lpht_cmd_t  cmd;
  lpht_pkg::lpht_stat_t stat;

  lpht_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  lpht_datapath #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .req_type   (req_type),
    .key        (key),
    .data_in    (data_in),
    .done       (done),
    .status     (status),
    .data_out   (data_out),
    .slot_index (slot_index)
  );

  // An accepted transaction keeps the block busy until its result.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("block not busy after accepting a request");

  // A result only ends a transaction that was in progress.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a transaction in progress");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == lpht_pkg::ST_OK || status == lpht_pkg::ST_NOT_FOUND ||
              status == lpht_pkg::ST_FULL))
    else $error("result carries an undefined status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != lpht_pkg::ST_OK |-> data_out == '0 && slot_index == '0)
    else $error("failed request returned nonzero data or slot");

endmodule

// ===== rtl/lpht_ctrl.sv =====
module lpht_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  lpht_pkg::lpht_stat_t stat,
  output lpht_pkg::lpht_cmd_t  cmd,
  output logic                 busy
);

  lpht_pkg::state_t state;
  lpht_pkg::state_t state_next;
  logic             req_valid;
  logic             finish;

  assign req_valid = (stat.req == lpht_pkg::REQ_INSERT) ||
                     (stat.req == lpht_pkg::REQ_SEARCH) ||
                     (stat.req == lpht_pkg::REQ_DELETE);
  assign finish    = cmd.res_ok | cmd.res_nf | cmd.res_full;
  assign busy      = (state != lpht_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lpht_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lpht_pkg::S_CLEAR: begin
        if (stat.clear_done) state_next = lpht_pkg::S_IDLE;
      end
      lpht_pkg::S_IDLE: begin
        if (start) state_next = lpht_pkg::S_HASH;
      end
      lpht_pkg::S_HASH: begin
        if (stat.hash_done) state_next = req_valid ? lpht_pkg::S_HOME : lpht_pkg::S_IDLE;
      end
      lpht_pkg::S_HOME: begin
        state_next = lpht_pkg::S_CHECK;
      end
      lpht_pkg::S_CHECK: begin
        if (finish) state_next = lpht_pkg::S_IDLE;
      end
      default: begin
        state_next = lpht_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      lpht_pkg::S_CLEAR: begin
        cmd.clr_en = 1'b1;
      end
      lpht_pkg::S_IDLE: begin
        cmd.load = start;
      end
      lpht_pkg::S_HASH: begin
        cmd.hash_en = 1'b1;
        // An unknown request code ends as soon as the key is reduced.
        if (stat.hash_done && !req_valid) cmd.res_nf = 1'b1;
      end
      lpht_pkg::S_HOME: begin
        cmd.rd_home = 1'b1;
      end
      lpht_pkg::S_CHECK: begin
        if (stat.req == lpht_pkg::REQ_INSERT) begin
          if (stat.mark != lpht_pkg::MARK_USED) begin
            cmd.wr_used = 1'b1;
            cmd.res_ok  = 1'b1;
          end else if (stat.last) begin
            cmd.res_full = 1'b1;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end else begin
          if (stat.mark == lpht_pkg::MARK_EMPTY) begin
            cmd.res_nf = 1'b1;
          end else if (stat.mark == lpht_pkg::MARK_USED && stat.key_eq) begin
            cmd.res_ok     = 1'b1;
            cmd.wr_deleted = (stat.req == lpht_pkg::REQ_DELETE);
          end else if (stat.last) begin
            cmd.res_nf = 1'b1;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/lpht_datapath.sv =====
module lpht_datapath #(
  parameter int TABLE_SIZE = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  lpht_pkg::lpht_cmd_t                  cmd,
  output lpht_pkg::lpht_stat_t                 stat,
  input  logic [lpht_pkg::REQ_W-1:0]           req_type,
  input  logic [lpht_pkg::KEY_W-1:0]           key,
  input  logic signed [lpht_pkg::DATA_W-1:0]   data_in,
  output logic                                 done,
  output logic [lpht_pkg::STATUS_W-1:0]        status,
  output logic signed [lpht_pkg::DATA_W-1:0]   data_out,
  output logic [lpht_pkg::SLOT_W-1:0]          slot_index
);

  localparam int IW      = $clog2(TABLE_SIZE);
  localparam int CW      = $clog2(TABLE_SIZE + 1);
  localparam int ENTRY_W = lpht_pkg::MARK_W + lpht_pkg::KEY_W + lpht_pkg::DATA_W;
  localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_SIZE - 1);
  localparam logic [CW-1:0] PROBE_MAX = CW'(TABLE_SIZE);

  // floor(key * RECIP / 2^RS) is the exact quotient for every 31-bit key.
  localparam int RS     = lpht_pkg::KEY_W + IW;
  localparam int PROD_W = 2 * lpht_pkg::KEY_W + 1;
  localparam longint RECIP_L = ((longint'(1) << RS) + longint'(TABLE_SIZE) - 1) /
                               longint'(TABLE_SIZE);
  localparam logic [lpht_pkg::KEY_W:0]   RECIP  = (lpht_pkg::KEY_W + 1)'(RECIP_L);
  localparam logic [lpht_pkg::KEY_W-1:0] TS_KEY = lpht_pkg::KEY_W'(TABLE_SIZE);

  logic [lpht_pkg::REQ_W-1:0]      req_r;
  logic [lpht_pkg::KEY_W-1:0]      key_r;
  logic [lpht_pkg::DATA_W-1:0]     data_r;
  logic [lpht_pkg::HASH_CNT_W-1:0] hash_cnt;
  logic [PROD_W-1:0]               prod;
  logic [lpht_pkg::KEY_W-1:0]      quot;
  logic [lpht_pkg::KEY_W-1:0]      quot_next;
  logic [lpht_pkg::KEY_W-1:0]      rem_full;
  logic [IW-1:0]                   home;
  logic [IW-1:0]                   home_next;
  logic [IW-1:0]                   pos;
  logic [IW-1:0]                   pos_inc;
  logic [IW+lpht_pkg::SLOT_W-1:0]  pos_ext;
  logic [CW-1:0]                   probe_cnt;
  logic [IW-1:0]                   clr_addr;

  logic [ENTRY_W-1:0]              mem [TABLE_SIZE];
  logic [ENTRY_W-1:0]              rd_data;
  logic [IW-1:0]                   rd_addr;
  logic                            wr_en;
  logic [IW-1:0]                   wr_addr;
  logic [lpht_pkg::MARK_W-1:0]     wr_mark;
  logic [ENTRY_W-1:0]              wr_data;

  logic [lpht_pkg::MARK_W-1:0]     rd_mark;
  logic [lpht_pkg::KEY_W-1:0]      rd_key;
  logic [lpht_pkg::DATA_W-1:0]     rd_val;

  assign prod      = PROD_W'(key_r) * PROD_W'(RECIP);
  assign quot_next = lpht_pkg::KEY_W'(prod >> RS);
  assign rem_full  = key_r - quot * TS_KEY;
  assign home_next = rem_full[IW-1:0];

  // The first reduction cycle registers the quotient, the second the remainder.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r    <= req_type;
      key_r    <= key;
      data_r   <= data_in;
      hash_cnt <= '0;
    end else if (cmd.hash_en) begin
      quot     <= quot_next;
      home     <= home_next;
      hash_cnt <= hash_cnt + 1'b1;
    end
  end

  assign pos_inc = (pos == LAST_SLOT) ? '0 : pos + 1'b1;
  assign pos_ext = (IW + lpht_pkg::SLOT_W)'(pos);

  always_ff @(posedge clk) begin
    if (cmd.rd_home) begin
      pos       <= home;
      probe_cnt <= CW'(1);
    end else if (cmd.rd_next) begin
      pos       <= pos_inc;
      probe_cnt <= probe_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_en) begin
      clr_addr <= (clr_addr == LAST_SLOT) ? '0 : clr_addr + 1'b1;
    end
  end

  // Each slot holds its mark, key and data word together; the read is registered,
  // so the next slot is addressed in the same cycle the current one is checked.
  assign rd_addr = cmd.rd_home ? home : pos_inc;
  assign wr_en   = cmd.clr_en | cmd.wr_used | cmd.wr_deleted;
  assign wr_addr = cmd.clr_en ? clr_addr : pos;
  assign wr_mark = cmd.clr_en     ? lpht_pkg::MARK_EMPTY :
                   cmd.wr_deleted ? lpht_pkg::MARK_DELETED : lpht_pkg::MARK_USED;
  assign wr_data = {wr_mark, key_r, data_r};

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  assign rd_mark = rd_data[ENTRY_W-1 -: lpht_pkg::MARK_W];
  assign rd_key  = rd_data[lpht_pkg::DATA_W +: lpht_pkg::KEY_W];
  assign rd_val  = rd_data[lpht_pkg::DATA_W-1:0];

  assign stat.req        = req_r;
  assign stat.hash_done  = (hash_cnt == lpht_pkg::HASH_CNT_W'(lpht_pkg::HASH_STEPS - 1));
  assign stat.clear_done = (clr_addr == LAST_SLOT);
  assign stat.mark       = rd_mark;
  assign stat.key_eq     = (rd_key == key_r);
  assign stat.last       = (probe_cnt == PROBE_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.res_ok | cmd.res_nf | cmd.res_full;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_ok) begin
      status     <= lpht_pkg::ST_OK;
      data_out   <= (req_r == lpht_pkg::REQ_INSERT) ? '0 : $signed(rd_val);
      slot_index <= pos_ext[lpht_pkg::SLOT_W-1:0];
    end else if (cmd.res_full) begin
      status     <= lpht_pkg::ST_FULL;
      data_out   <= '0;
      slot_index <= '0;
    end else if (cmd.res_nf) begin
      status     <= lpht_pkg::ST_NOT_FOUND;
      data_out   <= '0;
      slot_index <= '0;
    end
  end

endmodule
